@@ hdl/ccd_pkg.sv @@
// ccd_pkg: shared constants and word types for the constant column detector.
// Used by hdl/constant_column_detector.sv; no dependencies.

package ccd_pkg;

    localparam int MAX_COLS    = 64;
    localparam int SAMPLE_BITS = 32;
    localparam int COL_W       = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int CNT_W       = 7;
    localparam int TOL_W       = 31;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 31;
    localparam int DIFF_W      = SAMPLE_BITS + 1;
    localparam int CMP_W       = (DIFF_W > TOL_W) ? DIFF_W : TOL_W;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_CONST = 2'd2;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          last_of_matrix;
    } ccd_in_t;

    typedef struct packed {
        logic [MAX_COLS-1:0] variable_mask;
        logic                accepted;
        logic [CNT_W-1:0]    constant_count;
    } ccd_out_t;

endpackage

@@ hdl/constant_column_detector.sv @@
// constant_column_detector: top level, first-row store, compare and verdict logic.
// Depends on hdl/ccd_pkg.sv.

// Takes one matrix element per cycle, row-major, and keeps the first row in a
// 64-entry synchronous RAM. Each later element is compared with its column's
// first-row value; a column whose absolute difference exceeds the tolerance is
// marked variable once. A result word goes out when the constant column count
// drops below the minimum (rejected) or reaches zero (accepted if the minimum
// is zero), after which the rest of the matrix is dropped, or else on the
// element marked last. Throughput is one element per clock: the RAM read is
// issued as the element is taken, the element and read data are registered,
// and the compare works on those registers. The input stalls only while a result
// word is held by a stalled output. There is no clearing pass after reset.

module constant_column_detector (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [ccd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ccd_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  ccd_pkg::ccd_in_t              item,
    output logic                          result_valid,
    input  logic                          result_stall,
    output ccd_pkg::ccd_out_t             result
);

    import ccd_pkg::*;

    logic [CNT_W-1:0]       num_cols_reg;
    logic [TOL_W-1:0]       tolerance_reg;
    logic [CNT_W-1:0]       min_const_reg;

    logic [SAMPLE_BITS-1:0] store_mem [MAX_COLS];
    logic [SAMPLE_BITS-1:0] rdata_reg;

    logic                   b_valid_reg;
    logic [SAMPLE_BITS-1:0] b_sample_reg;
    logic                   b_last_reg;

    logic [COL_W-1:0]       col_idx_reg,   col_idx_next;
    logic                   first_row_reg, first_row_next;
    logic                   skip_reg,      skip_next;
    logic [MAX_COLS-1:0]    flags_reg,     flags_next;
    logic [CNT_W-1:0]       left_reg,      left_next;

    logic                   res_valid_reg;
    ccd_out_t               res_reg;

    logic [CNT_W-1:0]       n_eff;
    logic                   b_go;
    logic                   b_fire;
    logic                   accept;
    logic [CNT_W-1:0]       idx_inc;
    logic                   row_end;
    logic [COL_W-1:0]       idx_adv;
    logic [COL_W-1:0]       rd_addr;
    logic                   wr_en;
    logic signed [DIFF_W-1:0] diff;
    logic [DIFF_W-1:0]      abs_diff;
    logic                   over_tol;
    logic [MAX_COLS-1:0]    col_bit;
    logic                   new_var;
    logic [MAX_COLS-1:0]    flags_upd;
    logic [CNT_W-1:0]       left_upd;
    logic                   early;
    logic                   emit;
    logic                   emit_acc;
    logic                   restart;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_cols_reg  <= CNT_W'(MAX_COLS);
            tolerance_reg <= '0;
            min_const_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_NUM_COLS:  num_cols_reg  <= cfg_data[CNT_W-1:0];
                REG_TOLERANCE: tolerance_reg <= cfg_data[TOL_W-1:0];
                REG_MIN_CONST: min_const_reg <= cfg_data[CNT_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        if (num_cols_reg == '0)
            n_eff = CNT_W'(1);
        else if (num_cols_reg > CNT_W'(MAX_COLS))
            n_eff = CNT_W'(MAX_COLS);
        else
            n_eff = num_cols_reg;
    end

    // handshake
    assign b_go       = !(res_valid_reg && result_stall);
    assign b_fire     = b_valid_reg && b_go;
    assign item_stall = b_valid_reg && !b_go;
    assign accept     = item_valid && !item_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else if (accept)
            b_valid_reg <= 1'b1;
        else if (b_go)
            b_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            b_sample_reg <= item.sample;
            b_last_reg   <= item.last_of_matrix;
        end
    end

    // column advance; an item after an early verdict needs no read data
    assign idx_inc = CNT_W'(col_idx_reg) + CNT_W'(1);
    assign row_end = idx_inc >= n_eff;
    assign idx_adv = row_end ? '0 : idx_inc[COL_W-1:0];
    assign rd_addr = b_fire ? (b_last_reg ? '0 : idx_adv) : col_idx_reg;
    assign wr_en   = b_fire && !skip_reg && first_row_reg;

    // first-row store, with bypass when the read hits the entry being written
    always_ff @(posedge clk)
    begin
        if (wr_en)
            store_mem[col_idx_reg] <= b_sample_reg;
        if (accept)
        begin
            if (wr_en && (rd_addr == col_idx_reg))
                rdata_reg <= b_sample_reg;
            else
                rdata_reg <= store_mem[rd_addr];
        end
    end

    // compare
    assign diff     = $signed({b_sample_reg[SAMPLE_BITS-1], b_sample_reg})
                    - $signed({rdata_reg[SAMPLE_BITS-1], rdata_reg});
    assign abs_diff = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    assign over_tol = CMP_W'(abs_diff) > CMP_W'(tolerance_reg);
    assign col_bit  = MAX_COLS'(1) << col_idx_reg;
    assign new_var  = !skip_reg && !first_row_reg && over_tol
                    && ((flags_reg & col_bit) == '0);

    assign flags_upd = new_var ? (flags_reg | col_bit) : flags_reg;
    assign left_upd  = (new_var && left_reg != '0) ? left_reg - CNT_W'(1) : left_reg;
    assign early     = new_var && ((left_upd < min_const_reg) || (left_upd == '0));
    assign emit      = b_fire && !skip_reg && (early || b_last_reg);
    assign emit_acc  = early ? ((left_upd == '0) && (left_upd >= min_const_reg)) : 1'b1;
    assign restart   = b_fire && b_last_reg;

    always_comb
    begin
        col_idx_next   = col_idx_reg;
        first_row_next = first_row_reg;
        skip_next      = skip_reg;
        flags_next     = flags_reg;
        left_next      = left_reg;
        if (b_fire && !skip_reg)
        begin
            flags_next = flags_upd;
            left_next  = left_upd;
            if (early)
                skip_next = 1'b1;
            else
            begin
                col_idx_next = idx_adv;
                if (row_end)
                    first_row_next = 1'b0;
            end
        end
        if (restart)
        begin
            col_idx_next   = '0;
            first_row_next = 1'b1;
            skip_next      = 1'b0;
            flags_next     = '0;
            left_next      = n_eff;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_idx_reg   <= '0;
            first_row_reg <= 1'b1;
            skip_reg      <= 1'b0;
            flags_reg     <= '0;
            left_reg      <= CNT_W'(MAX_COLS);
        end
        else
        begin
            col_idx_reg   <= col_idx_next;
            first_row_reg <= first_row_next;
            skip_reg      <= skip_next;
            flags_reg     <= flags_next;
            left_reg      <= left_next;
        end
    end

    // result word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (emit)
            res_valid_reg <= 1'b1;
        else if (!result_stall)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            res_reg.variable_mask  <= flags_upd;
            res_reg.accepted       <= emit_acc;
            res_reg.constant_count <= left_upd;
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

`ifndef ASSERT_OFF
    a_left_range: assert property (@(posedge clk) disable iff (!rst_n)
        left_reg <= CNT_W'(MAX_COLS))
        else $error("constant count above column limit");

    a_skip_not_first: assert property (@(posedge clk) disable iff (!rst_n)
        skip_reg |-> !first_row_reg)
        else $error("dropping elements during first row");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (result_valid && b_valid_reg))
        else $error("input stalled without a held result word");

    a_flags_clear_first: assert property (@(posedge clk) disable iff (!rst_n)
        (first_row_reg && !skip_reg) |-> (flags_reg == '0))
        else $error("variable flag set during first row");
`endif

endmodule
